// ===== rtl/core/b92cd_pkg.sv =====
// Shared types, constants and symbol tables of the base-92 chunk decoder.
package b92cd_pkg;

  // Radix and chunk lengths.
  localparam int unsigned Radix        = 92;
  localparam int unsigned WideDigits   = 5;
  localparam int unsigned NarrowDigits = 2;

  // Longest message the count field describes; any count at or above seven
  // selects wide mode, so counts up to this bound need no clamping.
  localparam int unsigned MaxChars = 1023;

  // Depth of the chunk queue between the front and the back.
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam int unsigned DigitW  = 7;
  localparam int unsigned WeightW = 27;
  localparam int unsigned PosW    = 3;
  localparam int unsigned LeftW   = 10;

  // One finished chunk waiting to be serialized.
  typedef struct packed {
    logic [31:0] value;
    logic        wide;
    logic        msg_end;
  } chunk_t;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Maps one raw character code to its digit; codes outside the alphabet give 0.
  function automatic logic [DigitW-1:0] digit_of(input logic [7:0] code);
    logic [DigitW-1:0] d;
    d = '0;
    priority if (code >= 8'h61 && code <= 8'h7a) begin
      d = DigitW'(code - 8'h61);
    end else if (code >= 8'h41 && code <= 8'h5a) begin
      d = DigitW'(code - 8'h41 + 8'd26);
    end else if (code >= 8'h30 && code <= 8'h39) begin
      d = DigitW'(code - 8'h30 + 8'd52);
    end else begin
      unique case (code)
        8'h21: d = DigitW'(62);
        8'h24: d = DigitW'(63);
        8'h25: d = DigitW'(64);
        8'h5e: d = DigitW'(65);
        8'h26: d = DigitW'(66);
        8'h2a: d = DigitW'(67);
        8'h2d: d = DigitW'(68);
        8'h5f: d = DigitW'(69);
        8'h3d: d = DigitW'(70);
        8'h2b: d = DigitW'(71);
        8'h28: d = DigitW'(72);
        8'h29: d = DigitW'(73);
        8'h5b: d = DigitW'(74);
        8'h5d: d = DigitW'(75);
        8'h7b: d = DigitW'(76);
        8'h7d: d = DigitW'(77);
        8'h3c: d = DigitW'(78);
        8'h3e: d = DigitW'(79);
        8'h27: d = DigitW'(80);
        8'h40: d = DigitW'(81);
        8'h23: d = DigitW'(82);
        8'h7e: d = DigitW'(83);
        8'h3b: d = DigitW'(84);
        8'h3a: d = DigitW'(85);
        8'h2f: d = DigitW'(86);
        8'h3f: d = DigitW'(87);
        8'h2c: d = DigitW'(88);
        8'h2e: d = DigitW'(89);
        8'h7c: d = DigitW'(90);
        8'h5c: d = DigitW'(91);
        default: d = '0;
      endcase
    end
    return d;
  endfunction

  // Place weight of a digit position: 92 to the power of the position.
  function automatic logic [WeightW-1:0] weight_of(input logic [PosW-1:0] pos);
    logic [WeightW-1:0] w;
    unique case (pos)
      3'd0:    w = WeightW'(1);
      3'd1:    w = WeightW'(92);
      3'd2:    w = WeightW'(8464);
      3'd3:    w = WeightW'(778688);
      3'd4:    w = WeightW'(71639296);
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/b92cd_front.sv =====
// Front part: accepts characters, picks the chunk mode and accumulates digits.
module b92cd_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    symbol_i,
  input  logic [b92cd_pkg::LeftW-1:0]   chars_left_i,
  input  b92cd_pkg::q_status_t          q_status_i,
  output logic                          push_o,
  output b92cd_pkg::chunk_t             push_chunk_o
);

  logic [b92cd_pkg::PosW-1:0] pos_q, pos_d;
  logic                       wide_q, wide_d;
  logic [31:0]                acc_q, acc_d;

  logic                       accept;
  logic                       chunk_start;
  logic                       wide_now;
  logic                       left_le1, left_le2;
  logic [b92cd_pkg::PosW-1:0] need, pos_eff, pos_next;
  logic [31:0]                acc_base, acc_sum;
  logic [b92cd_pkg::DigitW+b92cd_pkg::WeightW-1:0] product;

  // A new character is taken whenever the queue has room for a chunk.
  assign in_ready_o = ~q_status_i.full;
  assign accept     = in_valid_i & in_ready_o;

  // Chunk mode and digit accumulation.
  always_comb begin
    chunk_start = (pos_q == '0);
    left_le1    = (chars_left_i <= b92cd_pkg::LeftW'(1));
    left_le2    = (chars_left_i <= b92cd_pkg::LeftW'(2));
    wide_now    = chunk_start
                  ? ((chars_left_i > b92cd_pkg::LeftW'(6)) ||
                     (chars_left_i == b92cd_pkg::LeftW'(5)))
                  : wide_q;
    acc_base    = chunk_start ? 32'd0 : acc_q;
    need        = wide_now ? b92cd_pkg::PosW'(b92cd_pkg::WideDigits)
                           : b92cd_pkg::PosW'(b92cd_pkg::NarrowDigits);
    pos_eff     = (pos_q >= need) ? '0 : pos_q;
    product     = b92cd_pkg::digit_of(symbol_i) * b92cd_pkg::weight_of(pos_eff);
    acc_sum     = acc_base + product[31:0];
    pos_next    = pos_eff + b92cd_pkg::PosW'(1);
  end

  // State update and chunk hand-off.
  always_comb begin
    pos_d                = pos_q;
    wide_d               = wide_q;
    acc_d                = acc_q;
    push_o               = 1'b0;
    push_chunk_o.value   = acc_sum;
    push_chunk_o.wide    = wide_now;
    push_chunk_o.msg_end = wide_now ? left_le1 : left_le2;
    if (accept) begin
      wide_d = wide_now;
      if (pos_next == need) begin
        // Chunk complete: hand it to the queue and start over.
        push_o = 1'b1;
        pos_d  = '0;
        acc_d  = '0;
      end else if (left_le1) begin
        // Message ends inside the chunk: the partial chunk is dropped.
        pos_d = '0;
        acc_d = '0;
      end else begin
        pos_d = pos_next;
        acc_d = acc_sum;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      wide_q <= 1'b0;
      acc_q  <= '0;
    end else begin
      pos_q  <= pos_d;
      wide_q <= wide_d;
      acc_q  <= acc_d;
    end
  end

endmodule

// ===== rtl/core/b92cd_queue.sv =====
// Short queue of finished chunks between the front and the back.
module b92cd_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  b92cd_pkg::chunk_t    push_chunk_i,
  input  logic                 pop_i,
  output b92cd_pkg::chunk_t    head_o,
  output b92cd_pkg::q_status_t status_o
);

  b92cd_pkg::chunk_t entries_q [b92cd_pkg::QDepth];

  logic [b92cd_pkg::QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [b92cd_pkg::QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [b92cd_pkg::QCntW-1:0] count_q, count_d;
  logic                        do_push, do_pop;

  // Status and head of the queue.
  assign status_o.full  = (count_q == b92cd_pkg::QCntW'(b92cd_pkg::QDepth));
  assign status_o.empty = (count_q == '0);
  assign head_o         = entries_q[rd_ptr_q];
  assign do_push        = push_i & ~status_o.full;
  assign do_pop         = pop_i & ~status_o.empty;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == b92cd_pkg::QPtrW'(b92cd_pkg::QDepth - 1))
                 ? '0 : wr_ptr_q + b92cd_pkg::QPtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == b92cd_pkg::QPtrW'(b92cd_pkg::QDepth - 1))
                 ? '0 : rd_ptr_q + b92cd_pkg::QPtrW'(1);
    end
    unique case ({do_push, do_pop})
      2'b10:   count_d = count_q + b92cd_pkg::QCntW'(1);
      2'b01:   count_d = count_q - b92cd_pkg::QCntW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage; payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_chunk_i;
    end
  end

endmodule

// ===== rtl/core/b92cd_back.sv =====
// Back part: serializes each queued chunk into its output bytes.
module b92cd_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  b92cd_pkg::chunk_t    head_i,
  input  b92cd_pkg::q_status_t q_status_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           data_byte_o,
  output logic                 run_last_o,
  output logic                 message_end_o
);

  logic [1:0] idx_q, idx_d;
  logic       last_byte;
  logic       out_accept;

  // Byte selection from the chunk at the head of the queue.
  assign out_valid_o   = ~q_status_i.empty;
  assign data_byte_o   = 8'(head_i.value >> {idx_q, 3'b000});
  assign last_byte     = ~head_i.wide | (idx_q == 2'd3);
  assign run_last_o    = last_byte;
  assign message_end_o = last_byte & head_i.msg_end;
  assign out_accept    = out_valid_o & out_ready_i;
  assign pop_o         = out_accept & last_byte;

  // Byte index within the current chunk.
  always_comb begin
    idx_d = idx_q;
    if (out_accept) begin
      idx_d = last_byte ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

// ===== rtl/core/base92_chunk_decoder.sv =====
// A chunk is queued as its last character is taken; the back sends its bytes.
// One character per cycle unless the queue is full; a wide chunk leaves as four bytes.
// Rate is set by the accumulator loop in the front (one digit per cycle) and the
// two-entry chunk queue that lets the byte serializer in the back run behind it.
// Reset: asynchronous, active low; clears chunk state and empties the queue.
// Top level of the base-92 chunk decoder.
module base92_chunk_decoder (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [7:0]                  symbol_i,
  input  logic [b92cd_pkg::LeftW-1:0] chars_left_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [7:0]                  data_byte_o,
  output logic                        run_last_o,
  output logic                        message_end_o
);

  logic                 push, pop;
  b92cd_pkg::chunk_t    push_chunk, head;
  b92cd_pkg::q_status_t q_status;

  // Character intake and accumulation.
  b92cd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .symbol_i     (symbol_i),
    .chars_left_i (chars_left_i),
    .q_status_i   (q_status),
    .push_o       (push),
    .push_chunk_o (push_chunk)
  );

  // Chunk queue.
  b92cd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_chunk_i (push_chunk),
    .pop_i        (pop),
    .head_o       (head),
    .status_o     (q_status)
  );

  // Byte serializer.
  b92cd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .q_status_i    (q_status),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .data_byte_o   (data_byte_o),
    .run_last_o    (run_last_o),
    .message_end_o (message_end_o)
  );

endmodule

// ===== rtl/core/b92cd_checker.sv =====
// Port-level checks of the base-92 chunk decoder and their binding.
module b92cd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] data_byte_o,
  input logic       run_last_o,
  input logic       message_end_o
);

  // No result is offered while reset is held.
  assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

  // A stalled output transaction stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output valid dropped before acceptance");

  // A stalled output transaction keeps its byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(data_byte_o))
    else $error("output byte changed while stalled");

  // The final byte of a message always closes its run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && message_end_o |-> run_last_o)
    else $error("message end outside the last byte of a run");

endmodule

bind base92_chunk_decoder b92cd_checker u_checker (.*);

// ===== tb/base92_chunk_decoder_test.sv =====
// Self-checking testbench for the base-92 chunk decoder: directed table, random messages.
module base92_chunk_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomItems = 385;
  localparam int HoldCycles  = 400;
  localparam int TailCycles  = 20;

  // One decoded byte as it leaves the block.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       run_last;
    logic       message_end;
  } byte_result_t;

  // One character to send; typed rows carry their own expected bytes.
  typedef struct packed {
    logic [7:0]                  sym;
    logic [b92cd_pkg::LeftW-1:0] cnt;
    bit                          typed;
    int                          n;
    logic [31:0]                 word;
    bit                          fin;
  } stim_row_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_ready_o;
  logic [7:0]                  symbol_i;
  logic [b92cd_pkg::LeftW-1:0] chars_left_i;
  logic                        out_valid_o;
  logic                        out_ready_i;
  logic [7:0]                  data_byte_o;
  logic                        run_last_o;
  logic                        message_end_o;

  // Decoder state as the predictor sees it.
  logic [31:0] chunk_acc;
  logic [31:0] place_wt;
  int          chunk_pos;
  bit          chunk_wide;

  byte_result_t expected_bytes[$];
  stim_row_t    cur_row;
  int           fail_count;
  int           tx_idle_pct;
  int           rx_idle_pct;
  bit           hold_req;

  string symbol_set =
    "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789!$%^&*-_=+()[]{}<>'@#~;:/?,.|\\";

  // Directed rows: narrow and wide chunks, extreme digits, foreign codes,
  // lone final character, dropped partial chunk, zero and largest counts.
  stim_row_t directed_rows [25] = '{
    '{8'h78, 10'd6,    1'b0, 0, 32'h0,        1'b0},  // count 6 opens a narrow chunk
    '{8'h61, 10'd1,    1'b1, 1, 32'h17,       1'b1},
    '{8'h5c, 10'd1,    1'b1, 0, 32'h0,        1'b0},  // lone final character
    '{8'h5c, 10'd5,    1'b1, 0, 32'h0,        1'b0},  // all-max wide chunk
    '{8'h5c, 10'd4,    1'b1, 0, 32'h0,        1'b0},
    '{8'h5c, 10'd3,    1'b1, 0, 32'h0,        1'b0},
    '{8'h5c, 10'd2,    1'b1, 0, 32'h0,        1'b0},
    '{8'h5c, 10'd1,    1'b1, 4, 32'h88D7DBFF, 1'b1},
    '{8'h5c, 10'd2,    1'b1, 0, 32'h0,        1'b0},  // all-max narrow chunk
    '{8'h5c, 10'd1,    1'b1, 1, 32'h0F,       1'b1},
    '{8'hff, 10'd5,    1'b1, 0, 32'h0,        1'b0},  // codes outside the alphabet
    '{8'h00, 10'd4,    1'b1, 0, 32'h0,        1'b0},
    '{8'h20, 10'd3,    1'b1, 0, 32'h0,        1'b0},
    '{8'h22, 10'd2,    1'b1, 0, 32'h0,        1'b0},
    '{8'h80, 10'd1,    1'b1, 4, 32'h0,        1'b1},
    '{8'h62, 10'd7,    1'b1, 0, 32'h0,        1'b0},  // message ends mid-chunk
    '{8'h63, 10'd1,    1'b1, 0, 32'h0,        1'b0},
    '{8'h5a, 10'd0,    1'b1, 0, 32'h0,        1'b0},  // zero count at chunk start
    '{8'h7a, 10'd3,    1'b0, 0, 32'h0,        1'b0},
    '{8'h39, 10'd0,    1'b0, 0, 32'h0,        1'b0},  // zero count closes a chunk
    '{8'h41, 10'd1023, 1'b0, 0, 32'h0,        1'b0},  // largest count
    '{8'h42, 10'd1022, 1'b0, 0, 32'h0,        1'b0},
    '{8'h43, 10'd1021, 1'b0, 0, 32'h0,        1'b0},
    '{8'h44, 10'd1020, 1'b0, 0, 32'h0,        1'b0},
    '{8'h45, 10'd1019, 1'b0, 0, 32'h0,        1'b0}
  };

  base92_chunk_decoder DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .symbol_i      (symbol_i),
    .chars_left_i  (chars_left_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .data_byte_o   (data_byte_o),
    .run_last_o    (run_last_o),
    .message_end_o (message_end_o)
  );

  always begin
    #5ns clk_i = 1'b1;
    #5ns clk_i = 1'b0;
  end

  // Digit of a character code; anything outside the alphabet is zero.
  function automatic logic [31:0] symbol_digit(input logic [7:0] code);
    for (int i = 0; i < b92cd_pkg::Radix; i++) begin
      if (symbol_set[i] == code) begin
        return 32'(i);
      end
    end
    return 32'd0;
  endfunction

  // Advances the chunk state by one character and returns the bytes it releases.
  function automatic int decode_step(input logic [7:0] sym,
                                     input logic [b92cd_pkg::LeftW-1:0] cnt,
                                     output byte_result_t out_bytes [4]);
    int unsigned left;
    int          need;
    left = (cnt == 0) ? 1 : cnt;
    if (chunk_pos == 0) begin
      chunk_wide = (left > 6 || left == 5);
      chunk_acc  = '0;
      place_wt   = 32'd1;
    end
    chunk_acc = chunk_acc + symbol_digit(sym) * place_wt;
    place_wt  = place_wt * b92cd_pkg::Radix;
    chunk_pos++;
    need = chunk_wide ? b92cd_pkg::WideDigits : b92cd_pkg::NarrowDigits;
    if (chunk_pos < need) begin
      // A message that ends inside a chunk drops the partial value.
      if (left <= 1) begin
        chunk_pos = 0;
      end
      return 0;
    end
    chunk_pos = 0;
    if (chunk_wide) begin
      for (int k = 0; k < 4; k++) begin
        out_bytes[k].data_byte   = chunk_acc[8*k +: 8];
        out_bytes[k].run_last    = (k == 3);
        out_bytes[k].message_end = (k == 3) && (left <= 1);
      end
      return 4;
    end
    out_bytes[0].data_byte   = chunk_acc[7:0];
    out_bytes[0].run_last    = 1'b1;
    out_bytes[0].message_end = (left <= 2);
    return 1;
  endfunction

  // Printable-heavy character mix with occasional raw byte codes.
  function automatic logic [7:0] random_symbol();
    if ($urandom_range(99) < 85) begin
      return symbol_set[$urandom_range(b92cd_pkg::Radix - 1)];
    end
    return 8'($urandom_range(255));
  endfunction

  // Offers one character after a random gap and waits for its transaction.
  task automatic send_char(input stim_row_t row);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    symbol_i     <= row.sym;
    chars_left_i <= row.cnt;
    cur_row      <= row;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // Checks each output transaction and predicts each input transaction.
  always @(posedge clk_i) begin : scoreboard
    byte_result_t want;
    byte_result_t step_bytes [4];
    int           n;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected output byte %02h", data_byte_o);
          fail_count++;
        end else begin
          want = expected_bytes.pop_front();
          if (data_byte_o !== want.data_byte) begin
            $error("data_byte: expected %02h, got %02h", want.data_byte, data_byte_o);
            fail_count++;
          end
          if (run_last_o !== want.run_last) begin
            $error("run_last: expected %0b, got %0b", want.run_last, run_last_o);
            fail_count++;
          end
          if (message_end_o !== want.message_end) begin
            $error("message_end: expected %0b, got %0b", want.message_end, message_end_o);
            fail_count++;
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        n = decode_step(symbol_i, chars_left_i, step_bytes);
        if (cur_row.typed) begin
          for (int k = 0; k < cur_row.n; k++) begin
            want.data_byte   = cur_row.word[8*k +: 8];
            want.run_last    = (k == cur_row.n - 1);
            want.message_end = want.run_last && cur_row.fin;
            expected_bytes.push_back(want);
          end
        end else begin
          for (int k = 0; k < n; k++) begin
            expected_bytes.push_back(step_bytes[k]);
          end
        end
      end
    end
  end

  // Output side: random back-pressure plus one long hold-off when requested.
  initial begin : receiver
    int hold_left;
    bit hold_done;
    hold_left   = 0;
    hold_done   = 1'b0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Stimulus: directed table, then random messages over three idle phases.
  initial begin : sender
    int          random_count;
    int          phase;
    int          pick;
    int          msg_len;
    int          start_cnt;
    stim_row_t   row;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    symbol_i     = '0;
    chars_left_i = '0;
    cur_row      = '0;
    hold_req     = 1'b0;
    fail_count   = 0;
    tx_idle_pct  = 16;
    rx_idle_pct  = 78;
    chunk_acc    = '0;
    place_wt     = 32'd1;
    chunk_pos    = 0;
    chunk_wide   = 1'b0;
    random_count = 0;
    phase        = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      send_char(directed_rows[i]);
    end

    // The receiver stalls for a long stretch while characters keep coming.
    hold_req <= 1'b1;
    while (random_count < RandomItems) begin
      if (phase == 0 && random_count >= RandomItems / 3) begin
        phase       = 1;
        tx_idle_pct = 78;
        rx_idle_pct <= 16;
      end else if (phase == 1 && random_count >= 2 * RandomItems / 3) begin
        // Drain completely before the phase with no idling.
        in_valid_i <= 1'b0;
        wait (expected_bytes.size() == 0);
        @(negedge clk_i);
        phase       = 2;
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
      end
      pick = $urandom_range(99);
      if (pick < 70) begin
        // Well-formed message, counts running down to one.
        msg_len = ($urandom_range(9) == 0) ? $urandom_range(60, 25) : $urandom_range(24, 1);
        for (int k = msg_len; k >= 1; k--) begin
          row = '{random_symbol(), b92cd_pkg::LeftW'(k), 1'b0, 0, 32'h0, 1'b0};
          send_char(row);
          random_count++;
        end
      end else if (pick < 88) begin
        // Truncated message that starts from any count.
        start_cnt = $urandom_range(1023);
        msg_len   = $urandom_range(8, 1);
        for (int k = 0; k < msg_len; k++) begin
          row = '{random_symbol(), b92cd_pkg::LeftW'((start_cnt > k) ? start_cnt - k : 0),
                  1'b0, 0, 32'h0, 1'b0};
          send_char(row);
          random_count++;
        end
      end else begin
        row = '{8'($urandom_range(255)), b92cd_pkg::LeftW'($urandom_range(1023)),
                1'b0, 0, 32'h0, 1'b0};
        send_char(row);
        random_count++;
      end
    end
    in_valid_i <= 1'b0;

    wait (expected_bytes.size() == 0);
    repeat (TailCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin : watchdog
    #2000000ns;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
